// File: hdl/ftdtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdtq_pkg
// Types and constants shared by the fixed-timeout delta timer queue.
// ----------------------------------------------------------------------------
package ftdtq_pkg;

  localparam int DELTA_W   = 8;
  localparam int TIMEOUT_W = 8;
  localparam int KIND_W    = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd6;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRED   = 2'd0,
    KIND_INSERTED  = 2'd1,
    KIND_DROPPED   = 2'd2,
    KIND_NO_EXPIRY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_HEAD  = 2'd1,
    ST_NEXT  = 2'd2,
    ST_FLUSH = 2'd3
  } state_t;

  typedef struct packed {
    logic ins;
    logic tick_idle;
    logic rd_head;
    logic head_step;
    logic next_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_one;
    logic head_zero;
    logic next_zero;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/ftdtq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftdtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/ftdtq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdtq_ctrl
// Sequencer: accepts beats, walks the head of the queue on a tick.
// ----------------------------------------------------------------------------
module ftdtq_ctrl
  import ftdtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output state_t     state
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = !((state_r == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;
  assign state    = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_TICK) && !status.empty) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (status.out_free) begin
          if (!status.head_zero) begin
            state_nxt = ST_IDLE;
          end else if (status.last_one) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (status.out_free) begin
          if (!status.next_zero) begin
            state_nxt = ST_IDLE;
          end else if (status.last_one) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.ins       = accept && (in_operation == OP_INSERT);
        cmd.tick_idle = accept && (in_operation == OP_TICK) && status.empty;
        cmd.rd_head   = accept && (in_operation == OP_TICK) && !status.empty;
      end
      ST_HEAD:  cmd.head_step = status.out_free;
      ST_NEXT:  cmd.next_step = status.out_free;
      ST_FLUSH: cmd.flush     = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: hdl/ftdtq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdtq_dpath
// Queue storage, pointers, delay total and the registered result beat.
// ----------------------------------------------------------------------------
module ftdtq_dpath
  import ftdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int MASK_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [MASK_BITS-1:0] in_switch_mask,
  input  logic                 cfg_valid,
  input  logic [TIMEOUT_W-1:0] cfg_timeout_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [MASK_BITS-1:0] out_expired_mask,
  output logic                 out_last_result,
  output logic                 out_queue_busy
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W = MASK_BITS + DELTA_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [SLOT_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt, nz_r, nz_nxt;
  logic [DELTA_W-1:0]   total_r, total_nxt;
  logic [MASK_BITS-1:0] pend_r, pend_nxt;

  logic                 ov_r, ov_nxt;
  kind_t                kind_r, kind_nxt;
  logic [MASK_BITS-1:0] omask_r, omask_nxt;
  logic                 olast_r, olast_nxt;
  logic                 obusy_r, obusy_nxt;

  logic                 full;
  logic [SLOT_W-1:0]    head_inc, tail_inc;
  logic [DELTA_W-1:0]   new_delta, rd_delta, dec_delta, total_dec;
  logic [MASK_BITS-1:0] rd_mask;
  logic [WORD_W-1:0]    rd_word, wr_word;
  logic                 wr_en, rd_en;
  logic [SLOT_W-1:0]    wr_addr, rd_addr;
  logic                 emit;

  assign full      = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign head_inc  = (head_r == SLOT_LAST) ? '0 : head_r + SLOT_W'(1);
  assign tail_inc  = (tail_r == SLOT_LAST) ? '0 : tail_r + SLOT_W'(1);
  assign new_delta = (timeout_r >= total_r) ? (timeout_r - total_r) : '0;
  assign rd_delta  = rd_word[DELTA_W-1:0];
  assign rd_mask   = rd_word[DELTA_W +: MASK_BITS];
  assign dec_delta = (rd_delta != '0) ? (rd_delta - DELTA_W'(1)) : '0;
  assign total_dec = (total_r != '0) ? (total_r - DELTA_W'(1)) : '0;

  assign status.empty     = (occ_r == '0);
  assign status.last_one  = (occ_r == OCC_W'(1));
  assign status.head_zero = (dec_delta == '0);
  assign status.next_zero = (rd_delta == '0);
  assign status.out_free  = !ov_r || !out_stall;

  assign wr_en   = (cmd.ins && !full) || (cmd.head_step && (dec_delta != '0));
  assign wr_addr = cmd.ins ? tail_r : head_r;
  assign wr_word = cmd.ins ? {in_switch_mask, new_delta} : {rd_mask, dec_delta};
  assign rd_en   = cmd.rd_head
                || (cmd.head_step && status.head_zero && !status.last_one)
                || (cmd.next_step && status.next_zero && !status.last_one);
  assign rd_addr = cmd.rd_head ? head_r : head_inc;

  ftdtq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    nz_nxt    = nz_r;
    total_nxt = total_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    kind_nxt  = kind_r;
    omask_nxt = omask_r;
    olast_nxt = olast_r;
    obusy_nxt = obusy_r;

    if (cmd.ins) begin
      emit      = 1'b1;
      omask_nxt = '0;
      olast_nxt = 1'b1;
      obusy_nxt = 1'b1;
      if (full) begin
        kind_nxt = KIND_DROPPED;
      end else begin
        kind_nxt  = KIND_INSERTED;
        tail_nxt  = tail_inc;
        occ_nxt   = occ_r + OCC_W'(1);
        total_nxt = timeout_r;
        if (new_delta != '0) begin
          nz_nxt = nz_r + OCC_W'(1);
        end
      end
    end

    if (cmd.tick_idle) begin
      emit      = 1'b1;
      kind_nxt  = KIND_NO_EXPIRY;
      omask_nxt = '0;
      olast_nxt = 1'b1;
      obusy_nxt = 1'b0;
    end

    if (cmd.head_step) begin
      total_nxt = total_dec;
      if (rd_delta == DELTA_W'(1)) begin
        nz_nxt = nz_r - OCC_W'(1);
      end
      if (!status.head_zero) begin
        emit      = 1'b1;
        kind_nxt  = KIND_NO_EXPIRY;
        omask_nxt = '0;
        olast_nxt = 1'b1;
        obusy_nxt = 1'b1;
      end else begin
        pend_nxt = rd_mask;
        head_nxt = head_inc;
        occ_nxt  = occ_r - OCC_W'(1);
        if (status.last_one) begin
          total_nxt = '0;
        end
      end
    end

    if (cmd.next_step) begin
      emit      = 1'b1;
      kind_nxt  = KIND_EXPIRED;
      omask_nxt = pend_r;
      olast_nxt = !status.next_zero;
      obusy_nxt = (nz_r != '0);
      if (status.next_zero) begin
        pend_nxt = rd_mask;
        head_nxt = head_inc;
        occ_nxt  = occ_r - OCC_W'(1);
        if (status.last_one) begin
          total_nxt = '0;
        end
      end
    end

    if (cmd.flush) begin
      emit      = 1'b1;
      kind_nxt  = KIND_EXPIRED;
      omask_nxt = pend_r;
      olast_nxt = 1'b1;
      obusy_nxt = 1'b0;
    end

    if (emit) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      nz_r      <= '0;
      total_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_timeout_ticks;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      nz_r    <= nz_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    kind_r  <= kind_nxt;
    omask_r <= omask_nxt;
    olast_r <= olast_nxt;
    obusy_r <= obusy_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = kind_r;
  assign out_expired_mask = omask_r;
  assign out_last_result  = olast_r;
  assign out_queue_busy   = obusy_r;

endmodule

// File: hdl/fixed_timeout_delta_timer_queue.sv
`timescale 1ns / 1ps
// An insert, or a tick on an empty queue, gives its beat in the cycle after acceptance.
// A tick on an occupied queue first reads and updates the head entry, then gives one beat
// per expired entry, paced by the single RAM read port and held while the output stalls.
// One insert per cycle if not stalled; a tick blocks input until its last beat is registered.
// Reset (synchronous, rst_n low): queue empty, delay total zero, timeout 6; RAM not cleared.
// ----------------------------------------------------------------------------
// fixed_timeout_delta_timer_queue
// Ring queue of switch masks that expire a fixed number of ticks after insertion.
// ----------------------------------------------------------------------------
module fixed_timeout_delta_timer_queue
  import ftdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int MASK_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [MASK_BITS-1:0] in_switch_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [MASK_BITS-1:0] out_expired_mask,
  output logic                 out_last_result,
  output logic                 out_queue_busy,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_timeout_ticks
);

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  assign cfg_ready = 1'b1;

  ftdtq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd),
    .state        (state)
  );

  ftdtq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MASK_BITS   (MASK_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_switch_mask    (in_switch_mask),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_expired_mask  (out_expired_mask),
    .out_last_result   (out_last_result),
    .out_queue_busy    (out_queue_busy)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_walk_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_HEAD || state == ST_NEXT) |-> !status.empty)
    else $error("head walk on an empty queue");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_FLUSH) |-> status.empty)
    else $error("final expiry with entries left");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken during a tick walk");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> (cmd.tick_idle == 1'b0 && cmd.flush == 1'b0
      && cmd.next_step == 1'b0 && cmd.ins == 1'b0))
    else $error("result issued over a held beat");

endmodule
